/* design/yuv_plane_squared_error_accumulator_core_defines.svh */
// Assertion macros shared by the squared-error accumulator checker
`ifndef YUV_PLANE_SQUARED_ERROR_ACCUMULATOR_CORE_DEFINES_SVH
`define YUV_PLANE_SQUARED_ERROR_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, held off while rst_n is low
`define YUVSSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, held off while rst_n is low
`define YUVSSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/yuvsse_pkg.sv */
// Types and constants of the YUV plane squared-error accumulator
package yuvsse_pkg;

  localparam int DEPTH_W = 5;
  localparam int SUM_W   = 64;

  localparam logic [DEPTH_W-1:0] DEPTH_MIN = 5'd8;

  typedef enum logic [1:0] {
    CFG_REF_DEPTH  = 2'd0,
    CFG_TEST_DEPTH = 2'd1,
    CFG_TGT_DEPTH  = 2'd2,
    CFG_MONO       = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

endpackage

/* design/yuv_plane_squared_error_accumulator_core.sv */
// Top level of the YUV plane squared-error accumulator
// Takes one reference/test sample pair per clock unless stalled, aligns both to the target
// depth, squares their difference and adds it into a saturating 64-bit sum
// while counting pairs. The pair flagged plane_end closes the plane: one
// request carrying the plane index, the sum and the pair count leaves on the
// out_ channel, and sum and count restart from zero. Plane order is Y, U, V,
// or Y only in monochrome. Sustained rate is one pair per clock while the input is not
// stalled; the last pair of a plane passes the align, absolute difference and multiply
// stages, then the accumulator into the result register.
// The input stalls only when a plane result reaches a result register still
// held by out_stall. Depth writes outside 8..SAMPLE_BITS are clamped into it.
// Write configuration only while the block is idle.
module yuv_plane_squared_error_accumulator_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 25
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [yuvsse_pkg::DEPTH_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SAMPLE_BITS-1:0]         in_ref_sample,
  input  logic [SAMPLE_BITS-1:0]         in_test_sample,
  input  logic                           in_plane_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_plane_index,
  output logic [yuvsse_pkg::SUM_W-1:0]   out_error_sum,
  output logic [COUNT_BITS-1:0]          out_plane_samples
);

  localparam int AW = 2 * SAMPLE_BITS - 8;
  localparam int QW = 2 * AW;
  localparam int DW = yuvsse_pkg::DEPTH_W;
  localparam int SW = yuvsse_pkg::SUM_W;

  // configuration, depths held already clamped
  logic [DW-1:0] ref_depth_r;
  logic [DW-1:0] test_depth_r;
  logic [DW-1:0] tgt_depth_r;
  logic          mono_r;
  logic [DW-1:0] depth_clamped;

  // pipeline
  logic          v1_r, v2_r, v3_r;
  logic          v1_nxt, v2_nxt, v3_nxt;
  logic          e1_r, e2_r, e3_r;
  logic [AW-1:0] a1_r, b1_r;
  logic [AW-1:0] a_al, b_al;
  logic [AW-1:0] d2_r;
  logic [QW-1:0] sq3_r;
  logic [AW-1:0] d_nxt;
  logic [QW-1:0] sq_nxt;
  logic          take1, take2, take3;
  logic          acc_go, out_free, close_plane;

  // accumulator and plane state
  logic [SW-1:0]         acc_r;
  logic [SW:0]           acc_wide;
  logic [SW-1:0]         acc_sat;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_inc;
  yuvsse_pkg::plane_t    plane_r, plane_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_plane_r;
  logic [SW-1:0]         out_sum_r;
  logic [COUNT_BITS-1:0] out_cnt_r;

  always_comb begin
    if (cfg_data < yuvsse_pkg::DEPTH_MIN) begin
      depth_clamped = yuvsse_pkg::DEPTH_MIN;
    end else if (cfg_data > DW'(SAMPLE_BITS)) begin
      depth_clamped = DW'(SAMPLE_BITS);
    end else begin
      depth_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_depth_r  <= yuvsse_pkg::DEPTH_MIN;
      test_depth_r <= yuvsse_pkg::DEPTH_MIN;
      tgt_depth_r  <= yuvsse_pkg::DEPTH_MIN;
      mono_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        yuvsse_pkg::CFG_REF_DEPTH:  ref_depth_r  <= depth_clamped;
        yuvsse_pkg::CFG_TEST_DEPTH: test_depth_r <= depth_clamped;
        yuvsse_pkg::CFG_TGT_DEPTH:  tgt_depth_r  <= depth_clamped;
        yuvsse_pkg::CFG_MONO:       mono_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  yuvsse_align #(.SAMPLE_BITS(SAMPLE_BITS)) u_align_ref (
    .smp        (in_ref_sample),
    .from_depth (ref_depth_r),
    .to_depth   (tgt_depth_r),
    .aligned    (a_al)
  );

  yuvsse_align #(.SAMPLE_BITS(SAMPLE_BITS)) u_align_test (
    .smp        (in_test_sample),
    .from_depth (test_depth_r),
    .to_depth   (tgt_depth_r),
    .aligned    (b_al)
  );

  // flow control: a stage takes a new request when empty or moving on
  always_comb begin
    out_free    = !out_valid_r || !out_stall;
    acc_go      = v3_r && (!e3_r || out_free);
    close_plane = acc_go && e3_r;
    take3       = !v3_r || acc_go;
    take2       = !v2_r || take3;
    take1       = !v1_r || take2;
    in_stall    = !take1;
    v1_nxt      = take1 ? in_valid : v1_r;
    v2_nxt      = take2 ? v1_r : v2_r;
    v3_nxt      = take3 ? v2_r : v3_r;
  end

  always_comb begin
    d_nxt  = (a1_r > b1_r) ? (a1_r - b1_r) : (b1_r - a1_r);
    sq_nxt = d2_r * d2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take1 && in_valid) begin
      a1_r <= a_al;
      b1_r <= b_al;
      e1_r <= in_plane_end;
    end
    if (take2 && v1_r) begin
      d2_r <= d_nxt;
      e2_r <= e1_r;
    end
    if (take3 && v2_r) begin
      sq3_r <= sq_nxt;
      e3_r  <= e2_r;
    end
  end

  // saturating sum and count
  always_comb begin
    acc_wide = {1'b0, acc_r} + (SW+1)'(sq3_r);
    acc_sat  = acc_wide[SW] ? {SW{1'b1}} : acc_wide[SW-1:0];
    cnt_inc  = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
  end

  always_comb begin
    plane_nxt = plane_r;
    if (close_plane) begin
      case (plane_r)
        yuvsse_pkg::PLANE_Y: plane_nxt = mono_r ? yuvsse_pkg::PLANE_Y : yuvsse_pkg::PLANE_U;
        yuvsse_pkg::PLANE_U: plane_nxt = mono_r ? yuvsse_pkg::PLANE_Y : yuvsse_pkg::PLANE_V;
        default:             plane_nxt = yuvsse_pkg::PLANE_Y;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cnt_r   <= '0;
      plane_r <= yuvsse_pkg::PLANE_Y;
    end else begin
      plane_r <= plane_nxt;
      if (close_plane) begin
        acc_r <= '0;
        cnt_r <= '0;
      end else if (acc_go) begin
        acc_r <= acc_sat;
        cnt_r <= cnt_inc;
      end
    end
  end

  // result register: load on plane close, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (close_plane) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (close_plane) begin
      out_plane_r <= plane_r;
      out_sum_r   <= acc_sat;
      out_cnt_r   <= cnt_inc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_plane_index   = out_plane_r;
  assign out_error_sum     = out_sum_r;
  assign out_plane_samples = out_cnt_r;

endmodule

/* design/yuvsse_align.sv */
// Sample alignment: round, shift and clip, or shift up, to the target depth
module yuvsse_align #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic [SAMPLE_BITS-1:0]        smp,
  input  logic [yuvsse_pkg::DEPTH_W-1:0] from_depth,
  input  logic [yuvsse_pkg::DEPTH_W-1:0] to_depth,
  output logic [2*SAMPLE_BITS-9:0]      aligned
);

  localparam int SW = SAMPLE_BITS;
  localparam int AW = 2 * SAMPLE_BITS - 8;

  logic [yuvsse_pkg::DEPTH_W-1:0] sh_up;
  logic [yuvsse_pkg::DEPTH_W-1:0] sh_dn;
  logic [SW:0]                    maxv;
  logic [SW:0]                    rnd;
  logic [SW:0]                    v;

  always_comb begin
    sh_up = to_depth - from_depth;
    sh_dn = from_depth - to_depth;
    maxv  = ((SW+1)'(1) << to_depth) - (SW+1)'(1);
    // round half up before dropping the low bits
    rnd   = (SW+1)'(smp) + ((SW+1)'(1) << (sh_dn - 1'b1));
    v     = (from_depth > to_depth) ? (rnd >> sh_dn) : (SW+1)'(smp);
    if (from_depth < to_depth) begin
      // shift up, no clip
      aligned = AW'(smp) << sh_up;
    end else if (v > maxv) begin
      aligned = AW'(maxv);
    end else begin
      aligned = AW'(v);
    end
  end

endmodule

/* design/yuvsse_checker.sv */
// Port-level checks for the squared-error accumulator, bound to the top level
`include "yuv_plane_squared_error_accumulator_core_defines.svh"

module yuvsse_checker #(
  parameter int COUNT_BITS = 25
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   out_plane_index,
  input logic [yuvsse_pkg::SUM_W-1:0] out_error_sum,
  input logic [COUNT_BITS-1:0]        out_plane_samples
);

  // input back-pressure only comes from a held plane result
  `YUVSSE_ASSERT_IMP(a_stall_source, in_valid && in_stall, out_valid && out_stall, "input stalled without a held result")

  // a closed plane holds at least one pair
  `YUVSSE_ASSERT_IMP(a_count_nonzero, out_valid, out_plane_samples != '0, "plane result with zero pairs")

  `YUVSSE_ASSERT_IMP(a_plane_code, out_valid, (out_plane_index == yuvsse_pkg::PLANE_Y) || (out_plane_index == yuvsse_pkg::PLANE_U) || (out_plane_index == yuvsse_pkg::PLANE_V), "bad plane index")

  // a held result keeps its payload
  `YUVSSE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_error_sum) && $stable(out_plane_samples) && $stable(out_plane_index), "held result changed")

endmodule

bind yuv_plane_squared_error_accumulator_core yuvsse_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_yuvsse_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_plane_index   (out_plane_index),
  .out_error_sum     (out_error_sum),
  .out_plane_samples (out_plane_samples)
);

/* sim/plane_error_checker.sv */
// Predictor and scoreboard for the plane results of the squared-error accumulator
`timescale 1ns / 1ps

module plane_error_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [yuvsse_pkg::DEPTH_W-1:0]     cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [SAMPLE_BITS-1:0]             in_ref_sample,
  input  logic [SAMPLE_BITS-1:0]             in_test_sample,
  input  logic                               in_plane_end,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [1:0]                         out_plane_index,
  input  logic [yuvsse_pkg::SUM_W-1:0]       out_error_sum,
  input  logic [COUNT_BITS-1:0]              out_plane_samples,
  output int                                 mismatches,
  output int                                 pending
);

  typedef struct {
    yuvsse_pkg::plane_t            plane;
    logic [yuvsse_pkg::SUM_W-1:0]  sum;
    logic [COUNT_BITS-1:0]         pairs;
  } plane_total_t;

  plane_total_t                   totals_due[$];
  plane_total_t                   head;
  logic [yuvsse_pkg::DEPTH_W-1:0] ref_depth;
  logic [yuvsse_pkg::DEPTH_W-1:0] test_depth;
  logic [yuvsse_pkg::DEPTH_W-1:0] tgt_depth;
  logic                           mono;
  logic [yuvsse_pkg::SUM_W-1:0]   running_sum;
  logic [COUNT_BITS-1:0]          running_pairs;
  yuvsse_pkg::plane_t             open_plane;
  int                             fail_count = 0;

  function automatic int eff_depth(logic [yuvsse_pkg::DEPTH_W-1:0] d);
    if (d < yuvsse_pkg::DEPTH_MIN) return int'(yuvsse_pkg::DEPTH_MIN);
    if (d > SAMPLE_BITS) return SAMPLE_BITS;
    return int'(d);
  endfunction

  // narrower samples move up unclipped; wider ones round half up, then clip
  function automatic logic [31:0] align_to(logic [SAMPLE_BITS-1:0] s, int src, int dst);
    int          sh;
    logic [31:0] v;
    logic [31:0] full;
    full = (32'd1 << dst) - 32'd1;
    if (src < dst) return 32'(s) << (dst - src);
    if (src > dst) begin
      sh = src - dst;
      v = (32'(s) + (32'd1 << (sh - 1))) >> sh;
    end else begin
      v = 32'(s);
    end
    return (v > full) ? full : v;
  endfunction

  task automatic fold_pair(logic [SAMPLE_BITS-1:0] r, logic [SAMPLE_BITS-1:0] t, logic last);
    int           dst;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  diff;
    logic [63:0]  sq;
    logic [64:0]  total;
    plane_total_t done;
    dst = eff_depth(tgt_depth);
    a = align_to(r, eff_depth(ref_depth), dst);
    b = align_to(t, eff_depth(test_depth), dst);
    diff = (a > b) ? a - b : b - a;
    sq = 64'(diff) * 64'(diff);
    total = {1'b0, running_sum} + {1'b0, sq};
    running_sum = total[64] ? '1 : total[63:0];
    if (running_pairs != '1) running_pairs++;
    if (last) begin
      done.plane = open_plane;
      done.sum = running_sum;
      done.pairs = running_pairs;
      totals_due.push_back(done);
      running_sum = '0;
      running_pairs = '0;
      if (mono) begin
        open_plane = yuvsse_pkg::PLANE_Y;
      end else begin
        case (open_plane)
          yuvsse_pkg::PLANE_Y: open_plane = yuvsse_pkg::PLANE_U;
          yuvsse_pkg::PLANE_U: open_plane = yuvsse_pkg::PLANE_V;
          default:             open_plane = yuvsse_pkg::PLANE_Y;
        endcase
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("plane_error_checker: %0t ns %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ref_depth = yuvsse_pkg::DEPTH_MIN;
      test_depth = yuvsse_pkg::DEPTH_MIN;
      tgt_depth = yuvsse_pkg::DEPTH_MIN;
      mono = 1'b0;
      running_sum = '0;
      running_pairs = '0;
      open_plane = yuvsse_pkg::PLANE_Y;
      totals_due.delete();
    end else begin
      if (cfg_we) begin
        case (yuvsse_pkg::cfg_idx_t'(cfg_index))
          yuvsse_pkg::CFG_REF_DEPTH:  ref_depth = cfg_data;
          yuvsse_pkg::CFG_TEST_DEPTH: test_depth = cfg_data;
          yuvsse_pkg::CFG_TGT_DEPTH:  tgt_depth = cfg_data;
          yuvsse_pkg::CFG_MONO:       mono = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) fold_pair(in_ref_sample, in_test_sample, in_plane_end);
      if (out_valid && !out_stall) begin
        if (totals_due.size() == 0) begin
          report_mismatch("result with no request outstanding, error_sum", out_error_sum, 0);
        end else begin
          head = totals_due.pop_front();
          if (out_plane_index !== head.plane)
            report_mismatch("plane_index", 64'(out_plane_index), 64'(head.plane));
          if (out_error_sum !== head.sum)
            report_mismatch("error_sum", out_error_sum, head.sum);
          if (out_plane_samples !== head.pairs)
            report_mismatch("plane_samples", 64'(out_plane_samples), 64'(head.pairs));
        end
      end
    end
    mismatches <= fail_count;
    pending <= totals_due.size();
  end

endmodule

/* sim/testbench.sv */
// Clock, reset, stimulus and verdict for the squared-error accumulator
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_BITS     = 16;
  localparam int COUNT_BITS      = 25;
  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int MAX_ERR_PAIRS   = 24;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_PAIRS     = 112;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [1:0]                     cfg_index = '0;
  logic [yuvsse_pkg::DEPTH_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [SAMPLE_BITS-1:0]         in_ref_sample = '0;
  logic [SAMPLE_BITS-1:0]         in_test_sample = '0;
  logic                           in_plane_end = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [1:0]                     out_plane_index;
  logic [yuvsse_pkg::SUM_W-1:0]   out_error_sum;
  logic [COUNT_BITS-1:0]          out_plane_samples;

  int mismatches;
  int pending;
  bit rx_pattern = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_taken = 1'b0;
  int ref_store_depth = 8;
  int test_store_depth = 8;
  int idle_cycles = 0;
  int hold_left = 0;
  int run_left = 0;
  bit stalling = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  yuv_plane_squared_error_accumulator_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ref_sample    (in_ref_sample),
    .in_test_sample   (in_test_sample),
    .in_plane_end     (in_plane_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plane_index  (out_plane_index),
    .out_error_sum    (out_error_sum),
    .out_plane_samples(out_plane_samples)
  );

  plane_error_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ref_sample    (in_ref_sample),
    .in_test_sample   (in_test_sample),
    .in_plane_end     (in_plane_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_plane_index  (out_plane_index),
    .out_error_sum    (out_error_sum),
    .out_plane_samples(out_plane_samples),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  // receiver: long hold-off on request; free/stalled runs alternate if rx_pattern
  always @(posedge clk) begin
    if (hold_off_req && !hold_taken) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!rx_pattern) begin
      out_stall <= 1'b0;
    end else begin
      if (run_left == 0) begin
        stalling = !stalling;
        run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 14);
      end
      run_left--;
      out_stall <= stalling;
    end
  end

  // drop the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  function automatic int store_depth(logic [yuvsse_pkg::DEPTH_W-1:0] d);
    if (d < 8) return 8;
    if (d > SAMPLE_BITS) return SAMPLE_BITS;
    return int'(d);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int depth);
    int full;
    full = (1 << depth) - 1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SAMPLE_BITS'(full);
      2:       return '1;
      3, 4:    return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
      default: return SAMPLE_BITS'($urandom_range(0, full));
    endcase
  endfunction

  // hold the request until the block takes it
  task automatic push_pair(logic [SAMPLE_BITS-1:0] r, logic [SAMPLE_BITS-1:0] t, logic last);
    in_valid <= 1'b1;
    in_ref_sample <= r;
    in_test_sample <= t;
    in_plane_end <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_for(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(yuvsse_pkg::cfg_idx_t idx, logic [yuvsse_pkg::DEPTH_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(logic [yuvsse_pkg::DEPTH_W-1:0] r,
                               logic [yuvsse_pkg::DEPTH_W-1:0] t,
                               logic [yuvsse_pkg::DEPTH_W-1:0] g,
                               logic [yuvsse_pkg::DEPTH_W-1:0] m);
    write_reg(yuvsse_pkg::CFG_REF_DEPTH, r);
    write_reg(yuvsse_pkg::CFG_TEST_DEPTH, t);
    write_reg(yuvsse_pkg::CFG_TGT_DEPTH, g);
    write_reg(yuvsse_pkg::CFG_MONO, m);
    cfg_we <= 1'b0;
    ref_store_depth = store_depth(r);
    test_store_depth = store_depth(t);
  endtask

  task automatic stream_planes(int n_pairs, int max_len, bit gaps);
    int                     sent;
    int                     plane_len;
    int                     burst_left;
    logic [SAMPLE_BITS-1:0] r;
    logic [SAMPLE_BITS-1:0] t;
    sent = 0;
    burst_left = $urandom_range(1, 24);
    while (sent < n_pairs) begin
      plane_len = ($urandom_range(0, 9) == 0) ? $urandom_range(max_len + 1, 4 * max_len + 8)
                                              : $urandom_range(1, max_len);
      for (int k = 0; k < plane_len; k++) begin
        r = pick_sample(ref_store_depth);
        t = ($urandom_range(0, 4) == 0) ? r : pick_sample(test_store_depth);
        push_pair(r, t, k == plane_len - 1);
        sent++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (gaps) idle_for($urandom_range(1, 8));
        end
      end
    end
  endtask

  initial begin
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    rx_pattern <= 1'b1;

    // reset depths: zero error, full-scale error, stray high bits clipped
    push_pair(16'h0000, 16'h0000, 1'b1);
    push_pair(16'h00FF, 16'h0000, 1'b0);
    push_pair(16'h0000, 16'h00FF, 1'b1);
    push_pair(16'hFFFF, 16'h00FF, 1'b1);
    push_pair(16'h0100, 16'h0000, 1'b1);

    // wide reference rounded half up to target, narrow test shifted up unclipped
    drain_and_settle();
    load_settings(5'd16, 5'd8, 5'd12, 5'd0);
    push_pair(16'hFFFF, 16'hFFFF, 1'b1);
    push_pair(16'h0007, 16'h0000, 1'b0);
    push_pair(16'h0008, 16'h0000, 1'b1);

    // depths outside the legal range, monochrome
    drain_and_settle();
    load_settings(5'd0, 5'd31, 5'd20, 5'd1);
    push_pair(16'hFFFF, 16'h0000, 1'b1);
    push_pair(16'h00FF, 16'hFFFF, 1'b1);

    // monochrome switched on with the second chroma plane still open
    drain_and_settle();
    load_settings(5'd8, 5'd8, 5'd8, 5'd0);
    push_pair(16'h0001, 16'h0002, 1'b1);
    push_pair(16'h0003, 16'h0001, 1'b1);
    drain_and_settle();
    load_settings(5'd8, 5'd8, 5'd8, 5'd1);
    push_pair(16'h000A, 16'h0014, 1'b1);
    push_pair(16'h0005, 16'h0005, 1'b1);
    drain_and_settle();
    load_settings(5'd8, 5'd8, 5'd8, 5'd0);
    push_pair(16'h0000, 16'h0000, 1'b1);
    push_pair(16'h0000, 16'h0000, 1'b0);
    push_pair(16'h0009, 16'h0000, 1'b1);

    // depths just outside the range, and rounding exactly at the half
    drain_and_settle();
    load_settings(5'd7, 5'd17, 5'd16, 5'd0);
    push_pair(16'hABCD, 16'h1234, 1'b1);
    drain_and_settle();
    load_settings(5'd16, 5'd16, 5'd8, 5'd0);
    push_pair(16'h7F80, 16'h7F7F, 1'b1);

    // one plane of maximum error, back to back
    drain_and_settle();
    load_settings(5'd8, 5'd16, 5'd16, 5'd0);
    rx_pattern <= 1'b0;
    for (int i = 0; i < MAX_ERR_PAIRS; i++)
      push_pair(16'hFFFF, 16'h0000, i == MAX_ERR_PAIRS - 1);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_and_settle();
      case (phase)
        0: load_settings(5'd8, 5'd8, 5'd8, 5'd0);
        1: load_settings(5'd16, 5'd16, 5'd16, 5'd1);
        2: load_settings(5'd8, 5'd16, 5'd16, 5'd0);
        3: load_settings(5'd16, 5'd8, 5'd8, 5'd0);
        4: load_settings(5'd31, 5'd0, 5'd0, 5'($urandom_range(0, 31)));
        default: load_settings(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                               5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      endcase
      rx_pattern <= (phase != 1 && phase != 5);
      if (phase == 3) begin
        // short planes back to back against a stalled receiver fill the block
        hold_off_req <= 1'b1;
        stream_planes(PHASE_PAIRS, 2, 1'b0);
      end else begin
        stream_planes(PHASE_PAIRS, 8, phase != 0 && phase != 6);
      end
    end

    drain_and_settle();
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
